// File: design/vnu_pkg.sv
// ----------------------------------------------------------------------------
// Vector normalise unit package
// Shared widths, operation codes, pipeline side-band types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package vnu_pkg;

    // Fixed-point format and derived widths.
    localparam int FRAC_BITS = 16;
    localparam int COMP_W    = 32;
    localparam int MAG_W     = COMP_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int DEN_W     = ROOT_W;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int Q_W       = DVD_W;
    localparam int NLANE     = 4;

    typedef enum logic [1:0] {
        OP_LENGTH = 2'd0,
        OP_NORM   = 2'd1,
        OP_PERSP  = 2'd2,
        OP_BAD    = 2'd3
    } op_t;

    // Side-band carried alongside the square-root pipeline.
    typedef struct packed {
        op_t                          op;
        logic [NLANE-1:0]             used;
        logic [NLANE-1:0][MAG_W-1:0]  mag;
        logic [NLANE-1:0]             neg;
    } side_t;

    // Side-band carried alongside the divider pipeline.
    typedef struct packed {
        logic                         err;
        logic                         len_valid;
        logic [NLANE-1:0]             used;
        logic [NLANE-1:0]             neg;
        logic [ROOT_W-1:0]            root;
    } dside_t;

    // Saturate an unsigned quotient magnitude and apply its sign.
    function automatic logic [COMP_W-1:0] sat_q(input logic [Q_W-1:0] q, input logic neg);
        logic [Q_W-1:0]    lim;
        logic [Q_W-1:0]    qs;
        logic [COMP_W-1:0] r;
        lim = neg ? (Q_W'(1) << (COMP_W - 1)) : ((Q_W'(1) << (COMP_W - 1)) - Q_W'(1));
        qs  = (q > lim) ? lim : q;
        r   = qs[COMP_W-1:0];
        return neg ? (~r + COMP_W'(1)) : r;
    endfunction

endpackage

`default_nettype wire

// File: design/vnu_sqrt.sv
// ----------------------------------------------------------------------------
// Vector normalise unit square root
// Fully pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnu_sqrt
    import vnu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [SUM_W-1:0]  in_rad,
    input  wire side_t             in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output side_t                  out_side
);

    logic              valid_reg [1:ROOT_W];
    logic [SUM_W-1:0]  rad_reg   [1:ROOT_W];
    logic [ROOT_W:0]   rem_reg   [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg  [1:ROOT_W];
    side_t             side_reg  [1:ROOT_W];

    genvar k;
    generate
        for (k = 1; k <= ROOT_W; k++) begin : g_stage
            logic              v_in;
            logic [SUM_W-1:0]  rad_in;
            logic [ROOT_W:0]   rem_in;
            logic [ROOT_W-1:0] root_in;
            side_t             side_in;
            logic [ROOT_W+2:0] t;
            logic [ROOT_W+2:0] trial;
            logic [ROOT_W:0]   rem_next;
            logic [ROOT_W-1:0] root_next;

            if (k == 1) begin : g_first
                assign v_in    = in_valid;
                assign rad_in  = in_rad;
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = in_side;
            end else begin : g_rest
                assign v_in    = valid_reg[k-1];
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            // Bring down the next two radicand bits and try the next root bit.
            always_comb
            begin
                t     = {rem_in, rad_in[SUM_W-1 -: 2]};
                trial = {1'b0, root_in, 2'b01};
                if (t >= trial)
                begin
                    rem_next  = (ROOT_W+1)'(t - trial);
                    root_next = {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = t[ROOT_W:0];
                    root_next = {root_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else
                    valid_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

`default_nettype wire

// File: design/vnu_div.sv
// ----------------------------------------------------------------------------
// Vector normalise unit divider
// Four pipelined restoring dividers sharing one divisor, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnu_div
    import vnu_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [DEN_W-1:0]             in_den,
    input  wire logic [NLANE-1:0][MAG_W-1:0]  in_mag,
    input  wire dside_t                       in_side,
    output logic                              out_valid,
    output logic [NLANE-1:0][Q_W-1:0]         out_q,
    output dside_t                            out_side
);

    logic                          valid_reg [1:DVD_W];
    logic [DEN_W-1:0]              den_reg   [1:DVD_W];
    logic [NLANE-1:0][DVD_W-1:0]   dvd_reg   [1:DVD_W];
    logic [NLANE-1:0][DEN_W-1:0]   rem_reg   [1:DVD_W];
    logic [NLANE-1:0][Q_W-1:0]     q_reg     [1:DVD_W];
    dside_t                        side_reg  [1:DVD_W];

    genvar k, l;
    generate
        for (k = 1; k <= DVD_W; k++) begin : g_stage
            logic                        v_in;
            logic [DEN_W-1:0]            den_in;
            logic [NLANE-1:0][DVD_W-1:0] dvd_in;
            logic [NLANE-1:0][DEN_W-1:0] rem_in;
            logic [NLANE-1:0][Q_W-1:0]   q_in;
            dside_t                      side_in;
            logic [NLANE-1:0][DEN_W-1:0] rem_next;
            logic [NLANE-1:0][Q_W-1:0]   q_next;

            if (k == 1) begin : g_first
                assign v_in    = in_valid;
                assign den_in  = in_den;
                assign rem_in  = '0;
                assign q_in    = '0;
                assign side_in = in_side;
                for (l = 0; l < NLANE; l++) begin : g_dvd
                    assign dvd_in[l] = {in_mag[l], {FRAC_BITS{1'b0}}};
                end
            end else begin : g_rest
                assign v_in    = valid_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign dvd_in  = dvd_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign q_in    = q_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            // One restoring step per lane.
            for (l = 0; l < NLANE; l++) begin : g_lane
                logic [DEN_W:0] t;
                always_comb
                begin
                    t = {rem_in[l], dvd_in[l][DVD_W-1]};
                    if (t >= {1'b0, den_in})
                    begin
                        rem_next[l] = DEN_W'(t - {1'b0, den_in});
                        q_next[l]   = {q_in[l][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = t[DEN_W-1:0];
                        q_next[l]   = {q_in[l][Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else
                    valid_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                den_reg[k]  <= den_in;
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_in;
                for (int i = 0; i < NLANE; i++)
                begin
                    dvd_reg[k][i] <= dvd_in[i] << 1;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DVD_W];
    assign out_q     = q_reg[DVD_W];
    assign out_side  = side_reg[DVD_W];

endmodule

`default_nettype wire

// File: design/vector_normalize_unit_core.sv
// ----------------------------------------------------------------------------
// Vector normalise unit core
// Length, normalise and perspective divide of fixed-point vectors.
// ----------------------------------------------------------------------------
// The unit takes one request in every clock cycle and never raises busy. Each
// request gives exactly one result, marked by done, after it has passed
// through the decode, squaring, pair-sum and total registers, the
// bit-per-stage square-root pipeline, the divisor selection register, the
// bit-per-stage divider pipeline and the output register. Results appear in
// request order and must be taken when shown.
`default_nettype none

module vector_normalize_unit_core
    import vnu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          req_type,
    input  wire logic [2:0]          dims,
    input  wire logic signed [31:0]  comp_x,
    input  wire logic signed [31:0]  comp_y,
    input  wire logic signed [31:0]  comp_z,
    input  wire logic signed [31:0]  comp_w,
    output logic                     done,
    output logic signed [31:0]       out_x,
    output logic signed [31:0]       out_y,
    output logic signed [31:0]       out_z,
    output logic signed [31:0]       out_w,
    output logic [31:0]              vec_length,
    output logic                     status
);

    logic [NLANE-1:0][COMP_W-1:0] comp;

    logic                         v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    side_t                        s1_reg, s2_reg, s3_reg, s4_reg;
    side_t                        s1_next;
    logic [NLANE-1:0][SQ_W-1:0]   sq2_reg;
    logic [SUM_W-2:0]             p0_reg, p1_reg;
    logic [SUM_W-1:0]             sum4_reg;

    logic                         sq_valid;
    logic [ROOT_W-1:0]            sq_root;
    side_t                        sq_side;

    logic [DEN_W-1:0]             den_reg, den_next;
    logic [NLANE-1:0][MAG_W-1:0]  mag5_reg;
    dside_t                       d5_reg, d5_next;

    logic                         dv_valid;
    logic [NLANE-1:0][Q_W-1:0]    dv_q;
    dside_t                       dv_side;

    logic                         done_reg;
    logic [NLANE-1:0][COMP_W-1:0] out_reg, out_next;
    logic [COMP_W-1:0]            len_reg, len_next;
    logic                         status_reg, status_next;

    assign busy = 1'b0;
    assign comp = {comp_w, comp_z, comp_y, comp_x};

    // Decode: operation, dimension mask, magnitudes and signs.
    always_comb
    begin
        s1_next.op = op_t'(req_type);
        if (dims <= 3'd2)
            s1_next.used = 4'b0011;
        else if (dims == 3'd3)
            s1_next.used = 4'b0111;
        else
            s1_next.used = 4'b1111;
        for (int i = 0; i < NLANE; i++)
        begin
            s1_next.neg[i] = comp[i][COMP_W-1];
            s1_next.mag[i] = comp[i][COMP_W-1] ? (~comp[i] + COMP_W'(1)) : comp[i];
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= sq_valid;
        end
    end

    // Front datapath: decode, square, pair sums, total.
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s1_reg;
        for (int i = 0; i < NLANE; i++)
        begin
            sq2_reg[i] <= s1_reg.used[i] ? (SQ_W'(s1_reg.mag[i]) * SQ_W'(s1_reg.mag[i])) : '0;
        end
        s3_reg   <= s2_reg;
        p0_reg   <= (SUM_W-1)'(sq2_reg[0]) + (SUM_W-1)'(sq2_reg[1]);
        p1_reg   <= (SUM_W-1)'(sq2_reg[2]) + (SUM_W-1)'(sq2_reg[3]);
        s4_reg   <= s3_reg;
        sum4_reg <= SUM_W'(p0_reg) + SUM_W'(p1_reg);
    end

    vnu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_rad    (sum4_reg),
        .in_side   (s4_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Divisor selection and error detection.
    always_comb
    begin
        d5_next.root      = sq_root;
        d5_next.err       = 1'b0;
        d5_next.len_valid = 1'b0;
        d5_next.used      = '0;
        d5_next.neg       = sq_side.neg;
        den_next          = sq_root;
        unique case (sq_side.op)
            OP_LENGTH:
            begin
                d5_next.err       = (sq_root == '0);
                d5_next.len_valid = 1'b1;
            end
            OP_NORM:
            begin
                d5_next.err       = (sq_root == '0);
                d5_next.len_valid = 1'b1;
                d5_next.used      = sq_side.used;
            end
            OP_PERSP:
            begin
                den_next     = DEN_W'(sq_side.mag[3]);
                d5_next.err  = (sq_side.mag[3] == '0);
                d5_next.used = 4'b0111;
                for (int i = 0; i < NLANE; i++)
                begin
                    d5_next.neg[i] = sq_side.neg[i] ^ sq_side.neg[3];
                end
            end
            default:
            begin
                d5_next.err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        mag5_reg <= sq_side.mag;
        d5_reg   <= d5_next;
    end

    vnu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_den    (den_reg),
        .in_mag    (mag5_reg),
        .in_side   (d5_reg),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    // Result composition with saturation and error masking.
    always_comb
    begin
        status_next = dv_side.err;
        len_next    = '0;
        if (!dv_side.err && dv_side.len_valid)
            len_next = dv_side.root[ROOT_W-1] ? '1 : dv_side.root[COMP_W-1:0];
        for (int i = 0; i < NLANE; i++)
        begin
            out_next[i] = (!dv_side.err && dv_side.used[i]) ? sat_q(dv_q[i], dv_side.neg[i]) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        len_reg    <= len_next;
        status_reg <= status_next;
    end

    assign done       = done_reg;
    assign out_x      = out_reg[0];
    assign out_y      = out_reg[1];
    assign out_z      = out_reg[2];
    assign out_w      = out_reg[3];
    assign vec_length = len_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire
